### sv/pidc_pkg.sv
// Package for the clamped PID controller: types and constants.
`timescale 1ns / 1ps
`default_nettype none
package pidc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned GainW   = 16;
  localparam int unsigned DivW    = 24;
  localparam int unsigned ProdW   = GainW + SumW;
  localparam int unsigned AccW    = ProdW + 2;
  localparam int unsigned FracShift = 12;
  localparam int unsigned CntW    = $clog2(DivW);
  localparam int unsigned AddrW   = 5;

  localparam logic [SampleW-1:0] DtOne = 16'd256;

  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_LIMIT_HIGH = 3'd3,
    REG_LIMIT_LOW  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DSAT,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_CLAMP,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

### sv/pid_controller_clamped.sv
// Clamped PID controller: sequencer, shared divider step and shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
// Takes one error sample and time step per transaction and returns one clamped
// drive value with a clamped flag. After acceptance, a 24-step restoring
// divider forms the derivative (one quotient bit per cycle), then one 16x32
// multiplier is used three times for the proportional, integral and derivative
// terms, followed by the clamp compare. The input is not ready until the result
// has been taken, so a new item is not accepted before the last one is through.
// The error sum and previous error are updated on acceptance; gains and limits
// are to be written over the APB port only while the block is idle; the block
// itself does not enforce this.
module pid_controller_clamped (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] error_sample, [31:16] time_step
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] drive
  output logic             m_axis_tuser,   // [0] clamped
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [pidc_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned SW = pidc_pkg::SampleW;
  localparam int unsigned DW = pidc_pkg::DivW;
  localparam int unsigned AW = pidc_pkg::AccW;

  pidc_pkg::state_e state_q, state_d;

  logic signed [SW-1:0] gain_p_q, gain_i_q, gain_d_q, lim_hi_q, lim_lo_q;
  logic signed [SW-1:0] prev_q, e_q, d_q;
  logic signed [pidc_pkg::SumW-1:0] sum_q;
  logic [SW-1:0]  dt_q;
  logic [DW-1:0]  quo_q;
  logic [SW:0]    rem_q;
  logic           neg_q;
  logic [pidc_pkg::CntW-1:0] cnt_q;
  logic signed [pidc_pkg::ProdW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [SW-1:0]  drive_q;
  logic           clamped_q;

  logic in_acc, out_acc, cfg_wr;
  pidc_pkg::reg_idx_e reg_idx;

  logic signed [SW:0]   diff;
  logic signed [SW+8:0] num;
  logic [SW+8:0]        mag;
  logic signed [pidc_pkg::SumW:0] sum_ext;
  logic signed [pidc_pkg::SumW-1:0] sum_sat;
  logic [SW:0]    rem_sh;
  logic           rem_ge;
  logic signed [SW-1:0] d_sat;
  logic signed [SW-1:0] mul_a;
  logic signed [pidc_pkg::SumW-1:0] mul_b;
  logic signed [pidc_pkg::ProdW-1:0] prod_d;
  logic signed [AW-1:0] hi_ext, lo_ext, acc_rnd;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = pidc_pkg::reg_idx_e'(paddr[4:2]);

  // Input-side arithmetic
  assign diff    = {s_axis_tdata[15], s_axis_tdata[15:0]} - {prev_q[SW-1], prev_q};
  assign num     = {diff, 8'd0};
  assign mag     = num[SW+8] ? -num : num;
  assign sum_ext = {sum_q[pidc_pkg::SumW-1], sum_q}
                 + (pidc_pkg::SumW+1)'($signed(s_axis_tdata[15:0]));

  always_comb begin
    if (sum_ext[pidc_pkg::SumW] != sum_ext[pidc_pkg::SumW-1]) begin
      sum_sat = sum_ext[pidc_pkg::SumW] ? {1'b1, {(pidc_pkg::SumW-1){1'b0}}}
                                        : {1'b0, {(pidc_pkg::SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[pidc_pkg::SumW-1:0];
    end
  end

  // Restoring division step
  assign rem_sh = {rem_q[SW-1:0], quo_q[DW-1]};
  assign rem_ge = rem_sh >= {1'b0, dt_q};

  // Derivative saturation
  always_comb begin
    if (neg_q) begin
      d_sat = (quo_q > DW'(32768)) ? 16'sh8000 : SW'(-quo_q);
    end else begin
      d_sat = (quo_q > DW'(32767)) ? 16'sh7fff : quo_q[SW-1:0];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      pidc_pkg::ST_MUL_P: begin
        mul_a = gain_p_q;
        mul_b = pidc_pkg::SumW'(e_q);
      end
      pidc_pkg::ST_MUL_I: begin
        mul_a = gain_i_q;
        mul_b = sum_q;
      end
      default: begin
        mul_a = gain_d_q;
        mul_b = pidc_pkg::SumW'(d_q);
      end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  assign hi_ext  = {{(AW-SW-pidc_pkg::FracShift){lim_hi_q[SW-1]}}, lim_hi_q,
                    {pidc_pkg::FracShift{1'b0}}};
  assign lo_ext  = {{(AW-SW-pidc_pkg::FracShift){lim_lo_q[SW-1]}}, lim_lo_q,
                    {pidc_pkg::FracShift{1'b0}}};
  assign acc_rnd = acc_q + AW'(2048);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidc_pkg::ST_IDLE:  if (in_acc) state_d = pidc_pkg::ST_DIV;
      pidc_pkg::ST_DIV:   if (cnt_q == pidc_pkg::CntW'(DW - 1)) state_d = pidc_pkg::ST_DSAT;
      pidc_pkg::ST_DSAT:  state_d = pidc_pkg::ST_MUL_P;
      pidc_pkg::ST_MUL_P: state_d = pidc_pkg::ST_MUL_I;
      pidc_pkg::ST_MUL_I: state_d = pidc_pkg::ST_MUL_D;
      pidc_pkg::ST_MUL_D: state_d = pidc_pkg::ST_ACC;
      pidc_pkg::ST_ACC:   state_d = pidc_pkg::ST_CLAMP;
      pidc_pkg::ST_CLAMP: state_d = pidc_pkg::ST_OUT;
      pidc_pkg::ST_OUT:   if (out_acc) state_d = pidc_pkg::ST_IDLE;
      default:            state_d = pidc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = (state_q == pidc_pkg::ST_IDLE);
    m_axis_tvalid = (state_q == pidc_pkg::ST_OUT);
    m_axis_tdata  = drive_q;
    m_axis_tuser  = clamped_q;
  end

  always_comb begin
    unique case (reg_idx)
      pidc_pkg::REG_GAIN_P:     prdata = 32'(gain_p_q);
      pidc_pkg::REG_GAIN_I:     prdata = 32'(gain_i_q);
      pidc_pkg::REG_GAIN_D:     prdata = 32'(gain_d_q);
      pidc_pkg::REG_LIMIT_HIGH: prdata = 32'(lim_hi_q);
      pidc_pkg::REG_LIMIT_LOW:  prdata = 32'(lim_lo_q);
      default:                  prdata = '0;
    endcase
  end

  // Control state, configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pidc_pkg::ST_IDLE;
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      lim_hi_q <= 16'sh7fff;
      lim_lo_q <= 16'sh8000;
      prev_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (reg_idx)
          pidc_pkg::REG_GAIN_P:     gain_p_q <= pwdata[SW-1:0];
          pidc_pkg::REG_GAIN_I:     gain_i_q <= pwdata[SW-1:0];
          pidc_pkg::REG_GAIN_D:     gain_d_q <= pwdata[SW-1:0];
          pidc_pkg::REG_LIMIT_HIGH: lim_hi_q <= pwdata[SW-1:0];
          pidc_pkg::REG_LIMIT_LOW:  lim_lo_q <= pwdata[SW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        prev_q <= s_axis_tdata[15:0];
        sum_q  <= sum_sat;
        cnt_q  <= '0;
      end else if (state_q == pidc_pkg::ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pidc_pkg::ST_IDLE: begin
        e_q   <= s_axis_tdata[15:0];
        dt_q  <= (s_axis_tdata[31:16] == '0) ? pidc_pkg::DtOne : s_axis_tdata[31:16];
        neg_q <= num[SW+8];
        quo_q <= mag[DW-1:0];
        rem_q <= '0;
      end
      pidc_pkg::ST_DIV: begin
        rem_q <= rem_ge ? rem_sh - {1'b0, dt_q} : rem_sh;
        quo_q <= {quo_q[DW-2:0], rem_ge};
      end
      pidc_pkg::ST_DSAT: d_q <= d_sat;
      pidc_pkg::ST_MUL_P: begin
        prod_q <= prod_d;
        acc_q  <= '0;
      end
      pidc_pkg::ST_MUL_I, pidc_pkg::ST_MUL_D: begin
        prod_q <= prod_d;
        acc_q  <= acc_q - AW'(prod_q);
      end
      pidc_pkg::ST_ACC: acc_q <= acc_q - AW'(prod_q);
      pidc_pkg::ST_CLAMP: begin
        priority if (acc_q > hi_ext) begin
          drive_q   <= lim_hi_q;
          clamped_q <= 1'b1;
        end else if (acc_q < lo_ext) begin
          drive_q   <= lim_lo_q;
          clamped_q <= 1'b1;
        end else begin
          drive_q   <= acc_rnd[pidc_pkg::FracShift+SW-1:pidc_pkg::FracShift];
          clamped_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for pid_controller_clamped: directed and random samples against a predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned StallMax      = 15;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned PhaseItems    = 190;
  localparam int unsigned SumRunItems   = 48;
  localparam logic [2:0]  RegSpare      = 3'd7;
  localparam longint      Unity         = 64'sd1 <<< pidc_pkg::FracShift;

  typedef struct packed {
    logic [15:0] drive;
    logic        clamped;
  } drive_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;   // [15:0] error_sample, [31:16] time_step
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [15:0]        m_axis_tdata;   // [15:0] drive
  logic               m_axis_tuser;   // [0] clamped
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [pidc_pkg::AddrW-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // controller mirror
  logic signed [15:0] gain_p_m = '0;
  logic signed [15:0] gain_i_m = '0;
  logic signed [15:0] gain_d_m = '0;
  logic signed [15:0] lim_hi_m = 16'h7FFF;
  logic signed [15:0] lim_lo_m = 16'h8000;
  logic signed [15:0] prev_err = '0;
  logic signed [31:0] err_sum  = '0;

  drive_t pending_drives[$];
  int     mismatch_count = 0;
  int     quiet_cycles   = 0;
  int     rx_hold        = 0;
  bit     tx_gaps_on     = 1'b1;
  bit     rx_stalls_on   = 1'b1;

  pid_controller_clamped dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH: %s", msg);
  endtask

  function automatic drive_t pid_step(input logic signed [15:0] e, input logic [15:0] dt);
    longint dt_v, deriv, sum_v, ctl;
    drive_t r;
    dt_v = (dt == '0) ? longint'(pidc_pkg::DtOne) : longint'(dt);
    deriv = ((longint'(e) - longint'(prev_err)) * 256) / dt_v;
    if (deriv > 32767) deriv = 32767;
    else if (deriv < -32768) deriv = -32768;
    sum_v = longint'(err_sum) + longint'(e);
    if (sum_v > 64'sd2147483647) sum_v = 64'sd2147483647;
    else if (sum_v < -64'sd2147483648) sum_v = -64'sd2147483648;
    err_sum  = sum_v[31:0];
    prev_err = e;
    ctl = -(longint'(gain_p_m) * longint'(e)) - (longint'(gain_i_m) * sum_v)
          - (longint'(gain_d_m) * deriv);
    if (ctl > longint'(lim_hi_m) * Unity) begin
      r.drive   = lim_hi_m;
      r.clamped = 1'b1;
    end else if (ctl < longint'(lim_lo_m) * Unity) begin
      r.drive   = lim_lo_m;
      r.clamped = 1'b1;
    end else begin
      ctl       = (ctl + Unity / 2) >>> pidc_pkg::FracShift;
      r.drive   = ctl[15:0];
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  task automatic send_sample(input logic [15:0] e, input logic [15:0] dt);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, StallMax) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, e};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pending_drives.push_back(pid_step(e, dt));
  endtask

  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_drives.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{16{val[15]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      pidc_pkg::REG_GAIN_P:     gain_p_m = val;
      pidc_pkg::REG_GAIN_I:     gain_i_m = val;
      pidc_pkg::REG_GAIN_D:     gain_d_m = val;
      pidc_pkg::REG_LIMIT_HIGH: lim_hi_m = val;
      pidc_pkg::REG_LIMIT_LOW:  lim_lo_m = val;
      default: ;
    endcase
    if (idx <= 3'(pidc_pkg::REG_LIMIT_LOW)) begin
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      if (prdata[15:0] !== val)
        report_mismatch($sformatf("reg %0d read %h, wrote %h", idx, prdata[15:0], val));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_controller(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] kd, input logic [15:0] hi,
                                input logic [15:0] lo);
    drain_results();
    write_reg(pidc_pkg::REG_GAIN_P, kp);
    write_reg(pidc_pkg::REG_GAIN_I, ki);
    write_reg(pidc_pkg::REG_GAIN_D, kd);
    write_reg(pidc_pkg::REG_LIMIT_HIGH, hi);
    write_reg(pidc_pkg::REG_LIMIT_LOW, lo);
  endtask

  function automatic logic [15:0] pick_word(input int spread);
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'(int'($urandom_range(0, 2 * spread)) - spread);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'($urandom_range(1, 16));
      3: return pidc_pkg::DtOne;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_register_map;
    set_controller(16'h0800, 16'h0010, 16'h0400, 16'h2000, 16'hE000);
    write_reg(RegSpare, 16'h7FFF);
    send_sample(16'h0100, pidc_pkg::DtOne);
    send_sample(16'hFE00, 16'h0080);
    send_sample(16'h0040, 16'h0000);
  endtask

  task automatic test_directed_cases;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    set_controller(16'h1000, 16'h0000, 16'h1000, 16'h7FFF, 16'h8000);
    send_sample(16'h0000, pidc_pkg::DtOne);
    send_sample(16'h7FFF, 16'h0000);   // zero step taken as one second
    send_sample(16'h8000, 16'h0001);   // derivative saturates low
    send_sample(16'h7FFF, 16'h0001);   // derivative saturates high
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0001, 16'h8000);
    // rounding half up
    set_controller(16'hF800, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
    send_sample(16'h0001, pidc_pkg::DtOne);
    send_sample(16'hFFFF, pidc_pkg::DtOne);
    send_sample(16'h0003, pidc_pkg::DtOne);
    // crossed limits
    set_controller(16'h1000, 16'h0000, 16'h0000, 16'hFF9C, 16'h0064);
    send_sample(16'h03E8, pidc_pkg::DtOne);
    send_sample(16'hFC18, pidc_pkg::DtOne);
    send_sample(16'h0000, pidc_pkg::DtOne);
    // most negative gains, narrow window
    set_controller(16'h8000, 16'h8000, 16'h8000, 16'h01F4, 16'hFE0C);
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h8000, 16'h0001);
    send_sample(16'h0000, 16'hFFFF);
    set_controller(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h7FFF, 16'hFFFF);
  endtask

  task automatic test_backpressure;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    set_controller(pick_word(4096), pick_word(64), pick_word(4096), 16'h4000, 16'hC000);
    rx_hold = HoldCycles;
    repeat (12) send_sample(16'($urandom), pick_step());
    drain_results();
    repeat (6) send_sample(16'($urandom), pick_step());
  endtask

  task automatic test_random_phases;
    for (int ph = 0; ph < 8; ph++) begin
      tx_gaps_on   = (ph % 3) != 2;
      rx_stalls_on = (ph % 4) != 3;
      if (ph == 0)
        set_controller(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      else if (ph == 1)
        set_controller(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
      else
        set_controller(pick_word(4096), pick_word(64), pick_word(4096),
                       pick_word(16384), pick_word(16384));
      repeat (PhaseItems) begin
        send_sample(($urandom_range(0, 3) == 0) ? pick_word(512) : 16'($urandom), pick_step());
      end
    end
  endtask

  // long one-sided run drives the error sum far from zero
  task automatic test_sum_drift;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    set_controller(16'h0000, 16'hFFFE, 16'h0000, 16'h7FFF, 16'h8000);
    repeat (SumRunItems) send_sample(16'h7FFF, pidc_pkg::DtOne);
    send_sample(16'h8000, pidc_pkg::DtOne);
  endtask

  initial begin : result_sink
    drive_t want;
    int     stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, StallMax) : 0;
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction drive=%h", m_axis_tdata));
      end else begin
        want = pending_drives.pop_front();
        if (m_axis_tdata !== want.drive)
          report_mismatch($sformatf("drive %h, expected %h", m_axis_tdata, want.drive));
        if (m_axis_tuser !== want.clamped)
          report_mismatch($sformatf("clamped %b, expected %b", m_axis_tuser, want.clamped));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_map();
    test_directed_cases();
    test_backpressure();
    test_random_phases();
    test_sum_drift();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
sv/pidc_pkg.sv
sv/pid_controller_clamped.sv
verif/tb_top.sv
